// ===== rtl/drca_pkg.sv =====
// Shared types and constants for the depth box change alert block.
// Used by every module under rtl; depends on nothing else.
package drca_pkg;

    // Fixed sizes of the block.
    localparam int WINDOW_LEN = 15;
    localparam int DEPTH_BITS = 16;
    localparam int COORD_BITS = 12;

    localparam int SUM_W  = 36;
    localparam int CNT_W  = 20;
    localparam int AVG_W  = 16;
    localparam int HCNT_W = $clog2(WINDOW_LEN + 1);
    localparam int HPTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WSUM_W = AVG_W + HCNT_W;
    localparam int CMP_W  = 14;
    localparam int RATIO_W = 12;
    localparam int LHS_W  = AVG_W + HCNT_W + 10;
    localparam int RHS_W  = RATIO_W + WSUM_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd5;

    // Opcodes of an input word.
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_EOF   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] depth_value;
    } in_word_t;

    typedef struct packed {
        logic [15:0] box_average;
        logic [15:0] window_mean;
        logic        alert;
        logic        empty_box;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_HIST,
        ST_ROLL,
        ST_DIV_ROLL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic pixel_acc;
        logic tick_inc;
        logic div_start;
        logic div_sel_roll;
        logic avg_capture;
        logic hist_update;
        logic prod_capture;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/drca_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on drca_pkg for its widths.
module drca_div
    import drca_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;
    logic                 ge;

    always_comb begin
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/drca_ctrl.sv =====
// Sequencer for the block: accepts words and steps the end-of-frame work.
// Depends on drca_pkg for the state, command and status types.
module drca_ctrl
    import drca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] opcode,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && opcode == OP_EOF) begin
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG: begin
                if (status.div_done) begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:     state_next = ST_ROLL;
            ST_ROLL:     state_next = ST_DIV_ROLL;
            ST_DIV_ROLL: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (opcode)
                        OP_PIXEL: cmd.pixel_acc = 1'b1;
                        OP_TICK:  cmd.tick_inc  = 1'b1;
                        OP_EOF:   cmd.div_start = 1'b1;
                        default:  cmd = '0;
                    endcase
                end
            end
            ST_DIV_AVG: cmd.avg_capture = status.div_done;
            ST_HIST:    cmd.hist_update = 1'b1;
            ST_ROLL: begin
                cmd.div_start    = 1'b1;
                cmd.div_sel_roll = 1'b1;
                cmd.prod_capture = 1'b1;
            end
            ST_DIV_ROLL: cmd = '0;
            ST_DONE:     cmd.finish = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== rtl/drca_dp.sv =====
// Datapath: configuration registers, box accumulators, frame history window,
// alert decision and the output register. Depends on drca_pkg and drca_div.
module drca_dp
    import drca_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              s_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    // Configuration.
    logic [12:0]        frame_width_reg;
    logic [12:0]        frame_height_reg;
    logic [9:0]         box_width_reg;
    logic [9:0]         box_height_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [7:0]         cooldown_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 13'd1280;
            frame_height_reg <= 13'd720;
            box_width_reg    <= 10'd100;
            box_height_reg   <= 10'd70;
            ratio_reg        <= 12'd1096;
            cooldown_reg     <= 8'd5;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_BOX_WIDTH:    box_width_reg    <= cfg_data[9:0];
                CFG_BOX_HEIGHT:   box_height_reg   <= cfg_data[9:0];
                CFG_RATIO:        ratio_reg        <= cfg_data[RATIO_W-1:0];
                CFG_COOLDOWN:     cooldown_reg     <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Box bounds, signed because the lower bound may fall below zero.
    logic signed [CMP_W-1:0] col_lo, col_hi, row_lo, row_hi, col_s, row_s;
    logic                    in_box;

    always_comb begin
        col_lo = $signed({2'b00, frame_width_reg[12:1]}) - $signed({5'b0, box_width_reg[9:1]});
        col_hi = $signed({2'b00, frame_width_reg[12:1]}) + $signed({5'b0, box_width_reg[9:1]});
        row_lo = $signed({2'b00, frame_height_reg[12:1]})
               - $signed({5'b0, box_height_reg[9:1]});
        row_hi = $signed({2'b00, frame_height_reg[12:1]})
               + $signed({5'b0, box_height_reg[9:1]});
        col_s  = $signed({{(CMP_W-COORD_BITS){1'b0}}, s_data.col[COORD_BITS-1:0]});
        row_s  = $signed({{(CMP_W-COORD_BITS){1'b0}}, s_data.row[COORD_BITS-1:0]});
        in_box = (col_s >= col_lo) && (col_s <= col_hi)
              && (row_s >= row_lo) && (row_s <= row_hi);
    end

    // Box accumulators with saturation.
    logic [SUM_W-1:0] box_sum_reg;
    logic [CNT_W-1:0] box_cnt_reg;
    logic [SUM_W:0]   sum_add;

    assign sum_add = {1'b0, box_sum_reg}
                   + {{(SUM_W+1-DEPTH_BITS){1'b0}}, s_data.depth_value[DEPTH_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_sum_reg <= '0;
            box_cnt_reg <= '0;
        end else if (cmd.finish) begin
            box_sum_reg <= '0;
            box_cnt_reg <= '0;
        end else if (cmd.pixel_acc && in_box) begin
            box_sum_reg <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            if (box_cnt_reg != {CNT_W{1'b1}}) begin
                box_cnt_reg <= box_cnt_reg + 1'b1;
            end
        end
    end

    // Shared divider for the box mean and the window mean.
    logic [HCNT_W-1:0] hcnt_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [SUM_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic [SUM_W-1:0]  div_quo;
    logic              div_done;

    assign div_dividend = cmd.div_sel_roll ? {{(SUM_W-WSUM_W){1'b0}}, wsum_reg} : box_sum_reg;
    assign div_divisor  = cmd.div_sel_roll ? {{(CNT_W-HCNT_W){1'b0}}, hcnt_reg} : box_cnt_reg;

    drca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [AVG_W-1:0] avg_reg;
    logic             empty_reg;

    always_ff @(posedge aclk) begin
        if (cmd.avg_capture) begin
            empty_reg <= (box_cnt_reg == '0);
            if (box_cnt_reg == '0) begin
                avg_reg <= '0;
            end else if (div_quo[SUM_W-1:AVG_W] != '0) begin
                avg_reg <= {AVG_W{1'b1}};
            end else begin
                avg_reg <= div_quo[AVG_W-1:0];
            end
        end
    end

    // Frame history window.
    logic [AVG_W-1:0]  hist_mem [WINDOW_LEN];
    logic [HPTR_W-1:0] hptr_reg;
    logic              hist_full;
    logic [WSUM_W-1:0] old_avg;

    assign hist_full = (hcnt_reg == HCNT_W'(WINDOW_LEN));
    assign old_avg   = hist_full ? {{(WSUM_W-AVG_W){1'b0}}, hist_mem[hptr_reg]} : '0;

    always_ff @(posedge aclk) begin
        if (cmd.hist_update) begin
            hist_mem[hptr_reg] <= avg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hptr_reg <= '0;
            hcnt_reg <= '0;
            wsum_reg <= '0;
        end else if (cmd.hist_update) begin
            wsum_reg <= wsum_reg - old_avg + {{(WSUM_W-AVG_W){1'b0}}, avg_reg};
            if (!hist_full) begin
                hcnt_reg <= hcnt_reg + 1'b1;
            end
            if (hptr_reg == HPTR_W'(WINDOW_LEN - 1)) begin
                hptr_reg <= '0;
            end else begin
                hptr_reg <= hptr_reg + 1'b1;
            end
        end
    end

    // Alert products and cooldown.
    logic [LHS_W-1:0] lhs_reg;
    logic [RHS_W-1:0] rhs_reg;
    logic [7:0]       ticks_reg;
    logic             alert;

    always_ff @(posedge aclk) begin
        if (cmd.prod_capture) begin
            lhs_reg <= {{{HCNT_W{1'b0}}, avg_reg} * {{AVG_W{1'b0}}, hcnt_reg}, 10'b0};
            rhs_reg <= {{(RHS_W-RATIO_W){1'b0}}, ratio_reg}
                     * {{(RHS_W-WSUM_W){1'b0}}, wsum_reg};
        end
    end

    assign alert = ({{(RHS_W-LHS_W){1'b0}}, lhs_reg} >= rhs_reg) && (ticks_reg > cooldown_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= 8'hFF;
        end else if (cmd.finish && alert) begin
            ticks_reg <= '0;
        end else if (cmd.tick_inc && ticks_reg != 8'hFF) begin
            ticks_reg <= ticks_reg + 1'b1;
        end
    end

    // Output register.
    logic      m_valid_reg;
    out_word_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg.box_average <= avg_reg;
            out_reg.window_mean <= div_quo[AVG_W-1:0];
            out_reg.alert       <= alert;
            out_reg.empty_box   <= empty_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ===== rtl/depth_roi_change_alert_unit.sv =====
// Top level of the depth box change alert block.
// Depends on drca_pkg, drca_ctrl, drca_dp (which holds drca_div).
//
//   Channel   Ports                          Carries
//   input     s_valid, s_ready, s_data       pixel, end-of-frame or tick word
//   result    m_valid, m_ready, m_data       one word per end of frame
//   config    cfg_we, cfg_index, cfg_data    register writes, no read-back
//
// Pixel and tick words may arrive back to back and are taken while the block is idle.
// An end-of-frame word holds off the next word until its work is done:
// the shared serial divider runs twice, for the box mean and then the
// window mean, with sequencing states around the two runs.
// Reset is synchronous and active low; it restores the default registers,
// clears the accumulators and the window, and allows the first alert.
// A stalled result word waits in the output register; pixels keep flowing,
// and only the next end of frame waits for that register to drain.
module depth_roi_change_alert_unit
    import drca_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The sequencer decides what happens each cycle; the datapath only acts
    // on its commands and reports divider completion and output space.
    drca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .opcode  (s_data.opcode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    drca_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // An empty box always reports a zero mean.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_box |-> m_data.box_average == '0)
        else $error("empty box word with nonzero box average");

    // Accepting an end-of-frame word stops intake while the means are worked out.
    a_eof_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.opcode == OP_EOF |=> !s_ready)
        else $error("input taken right after an end-of-frame word");

    // No result word is offered straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");
`endif

endmodule

// ===== tb/depth_roi_change_alert_unit_tb.sv =====
// Self-checking testbench for depth_roi_change_alert_unit: box mean, window mean, alert, empty flag.
// Depends on drca_pkg and the RTL under rtl; it needs no other file.
`timescale 1ns / 1ps

module depth_roi_change_alert_unit_tb
    import drca_pkg::*;
();

    // Opcode 3 has no meaning to the block; it is sent only as noise.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_WORDS  = 1950;
    localparam int QUIET_CYCLES  = 120;    // longer than one end-of-frame sequence
    localparam int DRAIN_LIMIT   = 100000;
    localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
    localparam longint unsigned CNT_LIMIT = (64'd1 << CNT_W) - 1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    depth_roi_change_alert_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Words waiting to be sent and frame reports the block still owes us.
    in_word_t  pending_words[$];
    out_word_t expected_reports[$];

    int error_count = 0;
    int words_queued = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_idle_off = 1'b0;
    bit recv_idle_off = 1'b0;

    // Our copy of the configuration registers, kept in step with every write.
    logic [12:0] frame_w = 13'd1280;
    logic [12:0] frame_h = 13'd720;
    logic [9:0]  box_w   = 10'd100;
    logic [9:0]  box_h   = 10'd70;
    logic [11:0] ratio_q10 = 12'd1096;
    logic [7:0]  cooldown  = 8'd5;

    // Our copy of the block's state. The first alert after reset is allowed,
    // which is why the tick counter starts saturated.
    longint unsigned acc_sum = 0;
    longint unsigned acc_cnt = 0;
    longint unsigned hist[WINDOW_LEN];
    int              hist_ptr = 0;
    int              hist_count = 0;
    longint unsigned win_sum = 0;
    int              tick_count = 255;

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Inclusive span test around the frame centre. Bounds are signed, so a box
    // wider than the frame simply covers the whole frame on that axis.
    function automatic bit in_box_span(input int pos, input int size, input int boxdim);
        int c;
        int h;
        c = size / 2;
        h = boxdim / 2;
        return (pos >= c - h) && (pos <= c + h);
    endfunction

    // Advance the predicted state by one accepted word, and queue the frame
    // report that an end of frame produces.
    task automatic predict_roi_word(input in_word_t w);
        longint unsigned avg;
        longint unsigned rolling;
        longint unsigned lhs;
        longint unsigned rhs;
        bit              empty;
        bit              alert;
        out_word_t       rep;
        case (w.opcode)
            OP_PIXEL: begin
                if (in_box_span(w.col, frame_w, box_w) && in_box_span(w.row, frame_h, box_h)) begin
                    acc_sum += w.depth_value;
                    if (acc_sum > SUM_LIMIT)
                        acc_sum = SUM_LIMIT;
                    if (acc_cnt < CNT_LIMIT)
                        acc_cnt++;
                end
            end
            OP_TICK: begin
                if (tick_count < 255)
                    tick_count++;
            end
            OP_EOF: begin
                empty = (acc_cnt == 0);
                avg = empty ? 0 : acc_sum / acc_cnt;
                if (avg > 65535)
                    avg = 65535;
                // Once the window is full the oldest average drops out.
                if (hist_count >= WINDOW_LEN)
                    win_sum -= hist[hist_ptr];
                else
                    hist_count++;
                hist[hist_ptr] = avg;
                win_sum += avg;
                hist_ptr = (hist_ptr + 1 >= WINDOW_LEN) ? 0 : hist_ptr + 1;
                rolling = win_sum / hist_count;
                // Alert when avg / mean >= ratio, compared without division.
                lhs = avg * hist_count * 1024;
                rhs = ratio_q10 * win_sum;
                alert = (lhs >= rhs) && (tick_count > cooldown);
                if (alert)
                    tick_count = 0;
                acc_sum = 0;
                acc_cnt = 0;
                rep.box_average = avg[15:0];
                rep.window_mean = rolling[15:0];
                rep.alert       = alert;
                rep.empty_box   = empty;
                expected_reports = {expected_reports, rep};
            end
            default: ;
        endcase
    endtask

    // Driver. A word is presented as soon as its idle gap has run out and it
    // is held, unchanged, until the block takes it. The gap is drawn when the
    // previous word is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_roi_word(s_data);
                void'(pending_words.pop_front());
                send_wait = send_idle_off ? 0 : $urandom_range(0, 10);
            end
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_words[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted report is compared with the oldest expected one.
    // After each report the receiver stalls for a random number of cycles;
    // the stall counts down whether or not a report is waiting.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    flag_mismatch($sformatf("report with none expected: %p", m_data));
                end else begin
                    if (m_data.box_average !== expected_reports[0].box_average)
                        flag_mismatch($sformatf("box_average got %0d expected %0d",
                            m_data.box_average, expected_reports[0].box_average));
                    if (m_data.window_mean !== expected_reports[0].window_mean)
                        flag_mismatch($sformatf("window_mean got %0d expected %0d",
                            m_data.window_mean, expected_reports[0].window_mean));
                    if (m_data.alert !== expected_reports[0].alert)
                        flag_mismatch($sformatf("alert got %b expected %b",
                            m_data.alert, expected_reports[0].alert));
                    if (m_data.empty_box !== expected_reports[0].empty_box)
                        flag_mismatch($sformatf("empty_box got %b expected %b",
                            m_data.empty_box, expected_reports[0].empty_box));
                    void'(expected_reports.pop_front());
                end
                recv_wait = recv_idle_off ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input logic [1:0] op, input int c, input int r, input int d);
        in_word_t w;
        w.opcode      = op;
        w.col         = c[11:0];
        w.row         = r[11:0];
        w.depth_value = d[15:0];
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // A tick or end of frame carries random bits in the fields it ignores.
    task automatic push_control(input logic [1:0] op);
        push_word(op, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
    endtask

    // A register is written only while the block is idle, so the mirror can
    // be updated as soon as the write is issued.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_FRAME_WIDTH:  frame_w   = value[12:0];
            CFG_FRAME_HEIGHT: frame_h   = value[12:0];
            CFG_BOX_WIDTH:    box_w     = value[9:0];
            CFG_BOX_HEIGHT:   box_h     = value[9:0];
            CFG_RATIO:        ratio_q10 = value[11:0];
            CFG_COOLDOWN:     cooldown  = value[7:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int fw, input int fh, input int bw, input int bh,
                              input int ratio, input int cd);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_BOX_WIDTH, bw);
        write_reg(CFG_BOX_HEIGHT, bh);
        write_reg(CFG_RATIO, ratio);
        write_reg(CFG_COOLDOWN, cd);
    endtask

    // Wait until every word has gone in and every report has come out, then
    // let extra cycles pass so that trailing pixels and ticks are absorbed.
    task automatic wait_quiet(input int extra);
        int n;
        n = 0;
        while ((pending_words.size() != 0 || s_valid || expected_reports.size() != 0)
               && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (extra) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Coordinate near the box on one axis: mostly inside, often right on an
    // edge, sometimes one step outside it.
    function automatic int span_coord(input int size, input int boxdim);
        int lo;
        int hi;
        int v;
        lo = size / 2 - boxdim / 2;
        hi = size / 2 + boxdim / 2;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        case ($urandom_range(0, 9))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo - 1;
            3:       v = hi + 1;
            default: v = $urandom_range(hi, lo);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // One frame: pixels around a depth level, with ticks and spare opcodes
    // mixed in, closed by an end of frame.
    task automatic queue_frame(input int n_pix, input int pct_in, input int level,
                               input int spread);
        int k;
        int c;
        int r;
        int d;
        for (k = 0; k < n_pix; k++) begin
            if ($urandom_range(0, 9) == 0)
                push_control(OP_TICK);
            if ($urandom_range(0, 29) == 0)
                push_control(OP_SPARE);
            if ($urandom_range(0, 99) < pct_in) begin
                c = span_coord(frame_w, box_w);
                r = span_coord(frame_h, box_h);
            end else begin
                c = $urandom_range(0, 4095);
                r = $urandom_range(0, 4095);
            end
            case ($urandom_range(0, 11))
                0:       d = 0;
                1:       d = 65535;
                2:       d = $urandom_range(0, 65535);
                default: d = level + int'($urandom_range(0, 2 * spread)) - spread;
            endcase
            if (d < 0)
                d = 0;
            if (d > 65535)
                d = 65535;
            push_word(OP_PIXEL, c, r, d);
        end
        push_control(OP_EOF);
    endtask

    initial begin
        int phase;
        int f;
        int k;
        int n_frames;
        int level;
        int spread;
        int n_pix;
        int pct_in;

        for (k = 0; k < WINDOW_LEN; k++)
            hist[k] = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words under the reset configuration: the box spans columns
        // 590..690 and rows 325..395. The first frame is empty and still gets
        // the first alert, since nothing has been alerted yet.
        push_word(OP_EOF, 0, 0, 0);
        push_word(OP_PIXEL, 590, 325, 65535);   // low corner
        push_word(OP_PIXEL, 690, 395, 0);       // high corner, zero depth counts
        push_word(OP_PIXEL, 690, 395, 0);       // the same pixel again counts again
        push_word(OP_PIXEL, 589, 325, 1000);    // one column left of the box
        push_word(OP_PIXEL, 691, 395, 1000);    // one column right of the box
        push_word(OP_PIXEL, 590, 324, 1000);    // one row above the box
        push_word(OP_PIXEL, 640, 396, 1000);    // one row below the box
        push_word(OP_PIXEL, 4095, 4095, 65535);
        push_word(OP_PIXEL, 0, 0, 65535);
        push_word(OP_SPARE, 640, 360, 65535);   // ignored even though it lies in the box
        push_word(OP_PIXEL, 640, 360, 65535);
        repeat (6) push_word(OP_TICK, 4095, 4095, 65535);
        push_word(OP_EOF, 4095, 4095, 65535);   // six ticks exceed the cooldown of five
        push_word(OP_TICK, 0, 0, 0);
        push_word(OP_EOF, 0, 0, 0);             // empty again, right after an alert
        wait_quiet(QUIET_CYCLES);

        phase = 0;
        level = 2000;
        while (words_queued < RANDOM_WORDS) begin
            case (phase)
                // Box far larger than a one-pixel frame; alert at every end of frame that follows a tick.
                0: set_config(1, 1, 1022, 1022, 0, 0);
                // Single-pixel box in the largest frame; the strictest alert.
                1: set_config(4096, 4096, 0, 0, 4095, 254);
                2: set_config(4096, 1, 1022, 0, 1024, 1);
                3: set_config(1, 4096, 0, 1022, 2048, 3);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_config($urandom_range(1, 4096), $urandom_range(1, 4096),
                                   $urandom_range(0, 1022), $urandom_range(0, 1022),
                                   $urandom_range(0, 4095), $urandom_range(0, 254));
                    else
                        set_config($urandom_range(1, 4096), $urandom_range(1, 4096),
                                   $urandom_range(0, 1022), $urandom_range(0, 1022),
                                   $urandom_range(900, 1400), $urandom_range(0, 12));
                end
            endcase
            send_idle_off = (phase % 4 == 3);
            recv_idle_off = (phase % 3 == 2);
            @(negedge aclk);

            // Drive the tick counter into saturation under the longest cooldown.
            if (phase == 1)
                repeat (300) push_control(OP_TICK);

            n_frames = $urandom_range(4, 10);
            for (f = 0; f < n_frames && words_queued < RANDOM_WORDS; f++) begin
                repeat ($urandom_range(0, 8)) push_control(OP_TICK);
                // Mostly a steady scene, now and then a jump that may alert.
                case ($urandom_range(0, 9))
                    6, 7:    level = $urandom_range(0, 65535);
                    8:       level = (level * 2 > 65535) ? 65535 : level * 2;
                    9:       level = level / 3;
                    default: ;
                endcase
                spread = $urandom_range(0, 200);
                n_pix  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
                pct_in = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(60, 100);
                queue_frame(n_pix, pct_in, level, spread);
                // Now and then the sender holds off until the block has caught up.
                if (phase % 5 == 1 && f == n_frames / 2)
                    wait_quiet(0);
            end
            wait_quiet(QUIET_CYCLES);
            phase++;
        end

        wait_quiet(QUIET_CYCLES);
        if (expected_reports.size() != 0)
            flag_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
